[design/srarq_pkg.sv]
// ----------------------------------------------------------------------------
// srarq_pkg
// Shared types, codes and constants of the selective-repeat window engine.
// ----------------------------------------------------------------------------
package srarq_pkg;

    localparam int SEQ_BITS  = 3;
    localparam int LEN_BITS  = 11;
    localparam int SLOT_BITS = SEQ_BITS - 1;
    localparam int WIN       = 1 << SLOT_BITS;
    localparam int CNT_BITS  = $clog2(WIN + 1);
    localparam int TMR_BITS  = 16;
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    localparam logic [LEN_BITS-1:0] HDR_LEN = LEN_BITS'(7);
    localparam logic [LEN_BITS-1:0] MIN_LEN = LEN_BITS'(5);

    localparam logic [TMR_BITS-1:0] DATA_TMO_RST = TMR_BITS'(2000);
    localparam logic [TMR_BITS-1:0] ACK_TMO_RST  = TMR_BITS'(1000);

    localparam logic REG_DATA_TMO = 1'b0;
    localparam logic REG_ACK_TMO  = 1'b1;

    typedef logic [SEQ_BITS-1:0]  t_seq;
    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [LEN_BITS-1:0]  t_len;
    typedef logic [TMR_BITS-1:0]  t_tmr;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef enum logic [2:0] {
        OP_PKT_READY  = 3'd0,
        OP_PHYS_READY = 3'd1,
        OP_FRAME_RX   = 3'd2,
        OP_DATA_TMO   = 3'd3,
        OP_ACK_TMO    = 3'd4
    } t_op;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    localparam logic [2:0] ACT_SEND_DATA = 3'd0;
    localparam logic [2:0] ACT_SEND_ACK  = 3'd1;
    localparam logic [2:0] ACT_SEND_NAK  = 3'd2;
    localparam logic [2:0] ACT_START_ACK = 3'd3;
    localparam logic [2:0] ACT_DELIVER   = 3'd4;
    localparam logic [2:0] ACT_STOP_DATA = 3'd5;
    localparam logic [2:0] ACT_STATUS    = 3'd6;

    typedef struct packed {
        logic [2:0] operation;
        logic       frame_ok;
        logic [1:0] frame_kind;
        t_seq       frame_seq;
        t_seq       peer_ack;
        t_len       frame_len;
        t_seq       timeout_seq;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        t_seq       seq_out;
        t_seq       ack_out;
        t_slot      slot;
        t_len       deliver_len;
        t_tmr       timer_value;
        logic       net_enable;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_seq lo;
        t_seq x;
        t_seq hi;
    } t_win_query;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_DELIV,
        S_DTIMER,
        S_ACKLOOP,
        S_STATUS
    } t_state;

endpackage

[design/srarq_cmp.sv]
// ----------------------------------------------------------------------------
// srarq_cmp
// Modular window test used by the first and ack-loop steps of the sequencer:
// x lies in [lo, hi) modulo the sequence space.
// ----------------------------------------------------------------------------
module srarq_cmp (
    input  srarq_pkg::t_win_query i_query,
    output logic                  o_in_window
);
    import srarq_pkg::*;

    t_seq dist_x;
    t_seq dist_hi;

    assign dist_x      = i_query.x - i_query.lo;
    assign dist_hi     = i_query.hi - i_query.lo;
    assign o_in_window = dist_x < dist_hi;

endmodule

[design/selective_repeat_arq_window.sv]
// ----------------------------------------------------------------------------
// selective_repeat_arq_window
// Sequence and window engine of a selective-repeat link.
// Flow: the event beat is registered, then the first step may emit an action; a
// good received frame whose length is stored then passes deliveries, each followed
// by an ack timer start, and stopped data timers come before the status beat.
// Events: one at a time; the next event beat is taken while the status beat is
// presented, and every step after the event beat holds while the output stalls.
// Reset: window edges return to their start; counters, arrived marks and phys-ready
// clear, timeouts return to 2000 and 1000; stored lengths keep their contents.
// ----------------------------------------------------------------------------
module selective_repeat_arq_window (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  srarq_pkg::t_in_item                    i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output srarq_pkg::t_out_item                   o_out_data,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [srarq_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [srarq_pkg::DATA_BITS-1:0]        pwdata,
    output logic [srarq_pkg::DATA_BITS-1:0]        prdata,
    output logic                                   pready
);
    import srarq_pkg::*;

    t_state    r_state,       n_state;
    t_in_item  r_in;
    t_seq      r_send_lower,  n_send_lower;
    t_seq      r_send_next,   n_send_next;
    t_seq      r_recv_lower,  n_recv_lower;
    t_seq      r_recv_upper,  n_recv_upper;
    t_cnt      r_outstanding, n_outstanding;
    logic      r_phys_ready,  n_phys_ready;
    logic [WIN-1:0] r_arrived, n_arrived;
    t_len      r_stored_len [WIN];
    logic      n_store_en;
    t_slot     n_store_slot;
    t_len      n_store_len;
    t_tmr      r_data_tmo;
    t_tmr      r_ack_tmo;
    logic      r_ovalid,      n_ovalid;
    t_out_item r_out,         n_out;

    t_win_query win_q;
    logic       win_hit;
    logic       can_emit;
    logic       cfg_wr;
    logic       in_beat;
    t_seq       ack_num;
    t_seq       nak_resend;
    t_slot      rl_slot;
    t_slot      rx_slot;
    t_len       rx_pkt_len;
    logic       bad_frame;

    srarq_cmp u_cmp (
        .i_query     (win_q),
        .o_in_window (win_hit)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_ACK_TMO) ? DATA_BITS'(r_ack_tmo)
                                                : DATA_BITS'(r_data_tmo);

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_beat     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign can_emit    = !r_ovalid || i_out_ready;

    assign ack_num    = r_recv_lower - t_seq'(1);
    assign nak_resend = r_in.peer_ack + t_seq'(1);
    assign rl_slot    = r_recv_lower[SLOT_BITS-1:0];
    assign rx_slot    = r_in.frame_seq[SLOT_BITS-1:0];
    assign rx_pkt_len = (r_in.frame_len >= HDR_LEN) ? (r_in.frame_len - HDR_LEN) : '0;
    assign bad_frame  = !r_in.frame_ok || (r_in.frame_len < MIN_LEN);

    always_comb begin
        win_q = '{lo: r_send_lower, x: r_in.peer_ack, hi: r_send_next};
        if (r_state == S_FIRST) begin
            if (r_in.frame_kind == KIND_DATA) begin
                win_q = '{lo: r_recv_lower, x: r_in.frame_seq, hi: r_recv_upper};
            end else begin
                win_q = '{lo: r_send_lower, x: nak_resend, hi: r_send_next};
            end
        end
    end

    always_comb begin
        t_out_item v_item;
        v_item         = '0;
        n_state        = r_state;
        n_send_lower   = r_send_lower;
        n_send_next    = r_send_next;
        n_recv_lower   = r_recv_lower;
        n_recv_upper   = r_recv_upper;
        n_outstanding  = r_outstanding;
        n_phys_ready   = r_phys_ready;
        n_arrived      = r_arrived;
        n_store_en     = 1'b0;
        n_store_slot   = rx_slot;
        n_store_len    = rx_pkt_len;
        n_ovalid       = r_ovalid && !i_out_ready;
        n_out          = r_out;

        if (can_emit || (r_state == S_IDLE)) begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        n_state = S_FIRST;
                    end
                end
                S_FIRST: begin
                    n_state = S_STATUS;
                    case (r_in.operation)
                        OP_PKT_READY: begin
                            if (r_outstanding < t_cnt'(WIN)) begin
                                v_item.action      = ACT_SEND_DATA;
                                v_item.seq_out     = r_send_next;
                                v_item.ack_out     = ack_num;
                                v_item.slot        = r_send_next[SLOT_BITS-1:0];
                                v_item.timer_value = r_data_tmo;
                                n_ovalid           = 1'b1;
                                n_phys_ready       = 1'b0;
                                n_outstanding      = r_outstanding + t_cnt'(1);
                                n_send_next        = r_send_next + t_seq'(1);
                            end
                        end
                        OP_PHYS_READY: begin
                            n_phys_ready = 1'b1;
                        end
                        OP_FRAME_RX: begin
                            if (bad_frame) begin
                                v_item.action  = ACT_SEND_NAK;
                                v_item.ack_out = ack_num;
                                n_ovalid       = 1'b1;
                                n_phys_ready   = 1'b0;
                            end else begin
                                n_state = S_ACKLOOP;
                                if (r_in.frame_kind == KIND_NAK) begin
                                    if (win_hit) begin
                                        v_item.action      = ACT_SEND_DATA;
                                        v_item.seq_out     = nak_resend;
                                        v_item.ack_out     = ack_num;
                                        v_item.slot        = nak_resend[SLOT_BITS-1:0];
                                        v_item.timer_value = r_data_tmo;
                                        n_ovalid           = 1'b1;
                                        n_phys_ready       = 1'b0;
                                    end
                                end else if (r_in.frame_kind == KIND_DATA) begin
                                    n_ovalid = 1'b1;
                                    if (r_in.frame_seq != r_recv_lower) begin
                                        v_item.action  = ACT_SEND_NAK;
                                        v_item.ack_out = ack_num;
                                        n_phys_ready   = 1'b0;
                                    end else begin
                                        v_item.action      = ACT_START_ACK;
                                        v_item.timer_value = r_ack_tmo;
                                    end
                                    if (win_hit && !r_arrived[rx_slot]) begin
                                        n_arrived[rx_slot] = 1'b1;
                                        n_store_en         = 1'b1;
                                        n_state            = S_DELIV;
                                    end
                                end
                            end
                        end
                        OP_DATA_TMO: begin
                            v_item.action      = ACT_SEND_DATA;
                            v_item.seq_out     = r_in.timeout_seq;
                            v_item.ack_out     = ack_num;
                            v_item.slot        = r_in.timeout_seq[SLOT_BITS-1:0];
                            v_item.timer_value = r_data_tmo;
                            n_ovalid           = 1'b1;
                            n_phys_ready       = 1'b0;
                        end
                        OP_ACK_TMO: begin
                            v_item.action  = ACT_SEND_ACK;
                            v_item.ack_out = ack_num;
                            n_ovalid       = 1'b1;
                            n_phys_ready   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                    if (n_ovalid && !(r_ovalid && !i_out_ready)) begin
                        n_out = v_item;
                    end
                end
                S_DELIV: begin
                    if (r_arrived[rl_slot]) begin
                        v_item.action      = ACT_DELIVER;
                        v_item.slot        = rl_slot;
                        v_item.deliver_len = r_stored_len[rl_slot];
                        n_out              = v_item;
                        n_ovalid           = 1'b1;
                        n_arrived[rl_slot] = 1'b0;
                        n_recv_lower       = r_recv_lower + t_seq'(1);
                        n_recv_upper       = r_recv_upper + t_seq'(1);
                        n_state            = S_DTIMER;
                    end else begin
                        n_state = S_ACKLOOP;
                    end
                end
                S_DTIMER: begin
                    v_item.action      = ACT_START_ACK;
                    v_item.timer_value = r_ack_tmo;
                    n_out              = v_item;
                    n_ovalid           = 1'b1;
                    n_state            = S_DELIV;
                end
                S_ACKLOOP: begin
                    if (win_hit) begin
                        v_item.action = ACT_STOP_DATA;
                        v_item.slot   = r_send_lower[SLOT_BITS-1:0];
                        n_out         = v_item;
                        n_ovalid      = 1'b1;
                        if (r_outstanding != '0) begin
                            n_outstanding = r_outstanding - t_cnt'(1);
                        end
                        n_send_lower = r_send_lower + t_seq'(1);
                    end else begin
                        n_state = S_STATUS;
                    end
                end
                S_STATUS: begin
                    v_item.action     = ACT_STATUS;
                    v_item.net_enable = (r_outstanding < t_cnt'(WIN)) && r_phys_ready;
                    v_item.last       = 1'b1;
                    n_out             = v_item;
                    n_ovalid          = 1'b1;
                    n_state           = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_send_lower  <= '0;
            r_send_next   <= '0;
            r_recv_lower  <= '0;
            r_recv_upper  <= t_seq'(WIN);
            r_outstanding <= '0;
            r_phys_ready  <= 1'b0;
            r_arrived     <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_send_lower  <= n_send_lower;
            r_send_next   <= n_send_next;
            r_recv_lower  <= n_recv_lower;
            r_recv_upper  <= n_recv_upper;
            r_outstanding <= n_outstanding;
            r_phys_ready  <= n_phys_ready;
            r_arrived     <= n_arrived;
            r_ovalid      <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_tmo <= DATA_TMO_RST;
            r_ack_tmo  <= ACK_TMO_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ACK_TMO) begin
                r_ack_tmo <= pwdata[TMR_BITS-1:0];
            end else begin
                r_data_tmo <= pwdata[TMR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_beat) begin
            r_in <= i_in_data;
        end
        if (n_store_en) begin
            r_stored_len[n_store_slot] <= n_store_len;
        end
    end

`ifndef SYNTHESIS
    a_outstanding_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= t_cnt'(WIN))
        else $error("outstanding count exceeds window");

    a_recv_window_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recv_upper == r_recv_lower + t_seq'(WIN))
        else $error("receive window edges out of step");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.action == ACT_STATUS))
        else $error("last beat is not a status beat");

    a_deliver_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DELIV && can_emit && r_arrived[rl_slot])
            |=> (r_recv_lower == $past(r_recv_lower) + t_seq'(1)))
        else $error("delivery did not advance the receive window");
`endif

endmodule
